// ----- rtl/multiword_number_mod_reduce_macros.svh -----
// Assertion macros for the multiword modular reduction block.
// Included by the top level; no other dependencies.
`ifndef MULTIWORD_NUMBER_MOD_REDUCE_MACROS_SVH
`define MULTIWORD_NUMBER_MOD_REDUCE_MACROS_SVH
`ifndef SYNTHESIS
`define MMR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define MMR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MMR_ASSERT_IMP(lbl, ante, cons, msg)
`define MMR_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/mmr_pkg.sv -----
// Shared types and constants for the multiword modular reduction block.
// No dependencies.
package mmr_pkg;

  localparam int XW            = 64;  // datapath width
  localparam int DEF_WORD_BITS = 64;
  localparam int CNT_W         = 7;   // holds iteration counts up to 64

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED_PR,
    ST_RED_WT,
    ST_BASE,
    ST_TERM,
    ST_ADD,
    ST_WMUL,
    ST_DONE
  } state_t;

  // Controls for one pass through the modular step unit
  typedef struct packed {
    logic dbl;
    logic add_en;
  } step_ctl_t;

  // Sequencer status toward the top level
  typedef struct packed {
    logic          ready;
    logic          res_valid;
    logic [XW-1:0] value;
  } seq_stat_t;

endpackage

// ----- rtl/mmr_modstep.sv -----
// Shared modular step unit: optional doubling then optional add, both mod m.
// Depends on mmr_pkg. A modulus of zero means plain 2^64 wraparound.
module mmr_modstep (
  input  logic [mmr_pkg::XW-1:0] acc,
  input  logic [mmr_pkg::XW-1:0] addend,
  input  logic [mmr_pkg::XW-1:0] m,
  input  mmr_pkg::step_ctl_t     ctl,
  output logic [mmr_pkg::XW-1:0] res
);

  // (a + b) mod m, a < m and b <= m
  function automatic logic [mmr_pkg::XW-1:0] add_mod(
    input logic [mmr_pkg::XW-1:0] a,
    input logic [mmr_pkg::XW-1:0] b,
    input logic [mmr_pkg::XW-1:0] mv
  );
    logic [mmr_pkg::XW:0] s;
    logic [mmr_pkg::XW:0] d;
    s = {1'b0, a} + {1'b0, b};
    d = s - {1'b0, mv};
    if (mv == '0) begin
      return s[mmr_pkg::XW-1:0];
    end else if (s >= {1'b0, mv}) begin
      return d[mmr_pkg::XW-1:0];
    end else begin
      return s[mmr_pkg::XW-1:0];
    end
  endfunction

  logic [mmr_pkg::XW-1:0] dbl_v;

  always_comb begin
    dbl_v = ctl.dbl ? add_mod(acc, acc, m) : acc;
    res   = ctl.add_en ? add_mod(dbl_v, addend, m) : dbl_v;
  end

endmodule

// ----- rtl/mmr_seq.sv -----
// Sequencer and operand registers around the shared modular step unit.
// Depends on mmr_pkg and mmr_modstep.
module mmr_seq #(
  parameter int WORD_BITS = mmr_pkg::DEF_WORD_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [mmr_pkg::XW-1:0] m,
  input  logic                   m_wr,
  input  logic                   in_valid,
  input  logic [mmr_pkg::XW-1:0] word_value,
  input  logic                   is_last,
  input  logic                   res_take,
  output mmr_pkg::seq_stat_t     stat
);

  localparam int SHIFT = mmr_pkg::XW - WORD_BITS;
  localparam logic [mmr_pkg::CNT_W-1:0] CNT_FULL = mmr_pkg::CNT_W'(mmr_pkg::XW - 1);
  localparam logic [mmr_pkg::CNT_W-1:0] CNT_WORD = mmr_pkg::CNT_W'(WORD_BITS - 1);
  localparam logic [mmr_pkg::CNT_W-1:0] CNT_BASE = mmr_pkg::CNT_W'(WORD_BITS);
  localparam logic [mmr_pkg::XW-1:0]    ONE      = mmr_pkg::XW'(1);
  localparam logic [mmr_pkg::XW-1:0]    SEED     = {1'b1, {(mmr_pkg::XW-1){1'b0}}};

  mmr_pkg::state_t state, state_next;

  logic [mmr_pkg::CNT_W-1:0] cnt;
  logic [mmr_pkg::XW-1:0]    acc;
  logic [mmr_pkg::XW-1:0]    sh;       // multiplier / dividend bits, MSB first
  logic [mmr_pkg::XW-1:0]    addend;
  logic [mmr_pkg::XW-1:0]    pr;       // partial remainder
  logic [mmr_pkg::XW-1:0]    weight;   // base^position mod m
  logic [mmr_pkg::XW-1:0]    base;     // 2^WORD_BITS mod m
  logic [mmr_pkg::XW-1:0]    word;
  logic                      last;
  logic                      stale;    // pr, weight, base not yet reduced by m

  logic                      accept;
  logic                      cnt_done;
  mmr_pkg::step_ctl_t        ctl;
  logic [mmr_pkg::XW-1:0]    unit_addend;
  logic [mmr_pkg::XW-1:0]    unit_res;

  assign accept   = in_valid && (state == mmr_pkg::ST_IDLE);
  assign cnt_done = (cnt == '0);

  mmr_modstep u_step (
    .acc    (acc),
    .addend (unit_addend),
    .m      (m),
    .ctl    (ctl),
    .res    (unit_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    ctl.dbl     = 1'b1;
    ctl.add_en  = sh[mmr_pkg::XW-1];
    unit_addend = addend;
    case (state)
      mmr_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = stale ? mmr_pkg::ST_RED_PR : mmr_pkg::ST_TERM;
        end
      end
      mmr_pkg::ST_RED_PR: begin
        unit_addend = ONE;
        if (cnt_done) begin
          state_next = mmr_pkg::ST_RED_WT;
        end
      end
      mmr_pkg::ST_RED_WT: begin
        unit_addend = ONE;
        if (cnt_done) begin
          state_next = mmr_pkg::ST_BASE;
        end
      end
      mmr_pkg::ST_BASE: begin
        unit_addend = ONE;
        if (cnt_done) begin
          state_next = mmr_pkg::ST_TERM;
        end
      end
      mmr_pkg::ST_TERM: begin
        if (cnt_done) begin
          state_next = mmr_pkg::ST_ADD;
        end
      end
      mmr_pkg::ST_ADD: begin
        ctl.dbl    = 1'b0;
        ctl.add_en = 1'b1;
        state_next = last ? mmr_pkg::ST_DONE : mmr_pkg::ST_WMUL;
      end
      mmr_pkg::ST_WMUL: begin
        if (cnt_done) begin
          state_next = mmr_pkg::ST_IDLE;
        end
      end
      mmr_pkg::ST_DONE: begin
        if (res_take) begin
          state_next = mmr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mmr_pkg::ST_IDLE;
      end
    endcase
  end

  // Stored values need a fresh reduction after reset or any modulus write
  always_ff @(posedge clk) begin
    if (rst) begin
      stale <= 1'b1;
    end else if (m_wr) begin
      stale <= 1'b1;
    end else if ((state == mmr_pkg::ST_BASE) && cnt_done) begin
      stale <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pr     <= '0;
      weight <= ONE;
    end else begin
      case (state)
        mmr_pkg::ST_IDLE: begin
          if (accept) begin
            word <= word_value;
            last <= is_last;
            acc  <= '0;
            if (stale) begin
              sh  <= pr;
              cnt <= CNT_FULL;
            end else begin
              sh     <= word_value << SHIFT;
              addend <= weight;
              cnt    <= CNT_WORD;
            end
          end
        end
        mmr_pkg::ST_RED_PR: begin
          if (cnt_done) begin
            pr  <= unit_res;
            acc <= '0;
            sh  <= weight;
            cnt <= CNT_FULL;
          end else begin
            acc <= unit_res;
            sh  <= sh << 1;
            cnt <= cnt - 1'b1;
          end
        end
        mmr_pkg::ST_RED_WT: begin
          if (cnt_done) begin
            weight <= unit_res;
            acc    <= '0;
            sh     <= SEED;
            cnt    <= CNT_BASE;
          end else begin
            acc <= unit_res;
            sh  <= sh << 1;
            cnt <= cnt - 1'b1;
          end
        end
        mmr_pkg::ST_BASE: begin
          if (cnt_done) begin
            base   <= unit_res;
            acc    <= '0;
            sh     <= word << SHIFT;
            addend <= weight;
            cnt    <= CNT_WORD;
          end else begin
            acc <= unit_res;
            sh  <= sh << 1;
            cnt <= cnt - 1'b1;
          end
        end
        mmr_pkg::ST_TERM: begin
          if (cnt_done) begin
            addend <= unit_res;
            acc    <= pr;
          end else begin
            acc <= unit_res;
            sh  <= sh << 1;
            cnt <= cnt - 1'b1;
          end
        end
        mmr_pkg::ST_ADD: begin
          if (last) begin
            acc    <= unit_res;
            pr     <= '0;
            weight <= ONE;
          end else begin
            pr     <= unit_res;
            acc    <= '0;
            sh     <= weight;
            addend <= base;
            cnt    <= CNT_FULL;
          end
        end
        mmr_pkg::ST_WMUL: begin
          acc <= unit_res;
          sh  <= sh << 1;
          cnt <= cnt - 1'b1;
          if (cnt_done) begin
            weight <= unit_res;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign stat.ready     = (state == mmr_pkg::ST_IDLE);
  assign stat.res_valid = (state == mmr_pkg::ST_DONE);
  assign stat.value     = acc;

endmodule

// ----- rtl/multiword_number_mod_reduce.sv -----
// The block takes no new word until the last one has run its term, add and weight update;
// a last word runs its term and add, then hands its remainder to the output register.
// After reset or a modulus write the next word first re-reduces remainder, weight and base.
// Throughput is set by the one shared mod-m double-and-add unit, one bit per cycle.
// Reset (synchronous, rst high): modulus 1, remainder 0, weight 1, output empty.
// Depends on mmr_pkg, mmr_seq, mmr_modstep and the macros header.
`include "multiword_number_mod_reduce_macros.svh"

module multiword_number_mod_reduce #(
  parameter int WORD_BITS = mmr_pkg::DEF_WORD_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration: modulus register, write only
  input  logic                   modulus_we,
  input  logic [mmr_pkg::XW-1:0] modulus,
  // input words, least significant first
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [mmr_pkg::XW-1:0] word_value,
  input  logic                   is_last,
  // one remainder per number
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [mmr_pkg::XW-1:0] remainder
);

  // Modulus register. Zero stands for 2^64 (plain wraparound arithmetic).
  logic [mmr_pkg::XW-1:0] m_value;
  mmr_pkg::seq_stat_t     stat;
  logic                   res_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_value <= mmr_pkg::XW'(1);
    end else if (modulus_we) begin
      m_value <= modulus;
    end
  end

  // The sequencer runs each word through the shared step unit:
  //   re-reduce remainder, weight and base after reset or a modulus change,
  //   term = word * weight, remainder += term, weight *= base (skipped on last).
  mmr_seq #(
    .WORD_BITS (WORD_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .m          (m_value),
    .m_wr       (modulus_we),
    .in_valid   (in_valid),
    .word_value (word_value),
    .is_last    (is_last),
    .res_take   (res_take),
    .stat       (stat)
  );

  assign in_ready = stat.ready;

  // Output register: the sequencer hands its result over as soon as the
  // register is empty or being drained in the same cycle, so the next
  // number can start while a remainder still waits downstream.
  assign res_take = stat.res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      remainder <= stat.value;
    end
  end

  // A word, once taken, leaves the block busy in the following cycle
  `MMR_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
                  "input accepted but block still ready next cycle")
  // An idle sequencer never holds an undelivered result
  `MMR_ASSERT_IMP(a_idle_no_result, in_ready, !stat.res_valid,
                  "sequencer idle with a pending result")
  // Every delivered remainder lies below a nonzero modulus
  `MMR_ASSERT_IMP(a_rem_in_range, out_valid && (m_value != '0), remainder < m_value,
                  "remainder not reduced below modulus")

endmodule

// ----- verif/tb_multiword_number_mod_reduce.sv -----
// Testbench for multiword_number_mod_reduce: directed table plus random numbers,
// every remainder checked against a typed-in value or an in-bench predictor. Depends on mmr_pkg and the RTL.
module tb_multiword_number_mod_reduce;

  localparam int XW        = mmr_pkg::XW;
  localparam int WBITS     = mmr_pkg::DEF_WORD_BITS;
  // Quiet time before a modulus write: covers a word still in flight after the
  // last remainder came out (word pass plus weight update plus margin).
  localparam int SETTLE_CYCLES   = 2 * 64 + WBITS + 66 + 140;
  localparam int N_PHASES        = 10;
  localparam int ITEMS_PER_PHASE = 135;
  localparam int HOLD_CYCLES     = 3000;
  localparam int HOLD_AT_RESULT  = 40;
  localparam logic [XW-1:0] ALL1 = {XW{1'b1}};

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t     kind;
    logic [XW-1:0] value;  // word, or modulus for a config row
    logic          last;
    logic          known;  // remainder typed in below
    logic [XW-1:0] want;
  } dir_row_t;

  // Directed table. Remainders are typed in only where they are obvious;
  // the others come from the predictor.
  localparam int N_ROWS = 25;
  dir_row_t dir_rows [N_ROWS] = '{
    '{ROW_WORD, ALL1,                   1'b1, 1'b1, 64'd0},  // reset modulus is 1
    '{ROW_CFG,  64'd0,                  1'b0, 1'b0, 64'd0},  // zero modulus: 2^64
    '{ROW_WORD, 64'h1234_5678_9ABC_DEF0, 1'b1, 1'b1, 64'h1234_5678_9ABC_DEF0},
    '{ROW_WORD, ALL1,                   1'b0, 1'b0, 64'd0},
    '{ROW_WORD, 64'd5,                  1'b1, 1'b1, ALL1},   // weight wraps to 0
    '{ROW_CFG,  ALL1,                   1'b0, 1'b0, 64'd0},  // largest modulus
    '{ROW_WORD, ALL1,                   1'b1, 1'b1, 64'd0},
    '{ROW_WORD, 64'd3,                  1'b0, 1'b0, 64'd0},
    '{ROW_WORD, 64'd2,                  1'b1, 1'b1, 64'd5},  // base mod m is 1
    '{ROW_CFG,  64'h8000_0000_0000_0000, 1'b0, 1'b0, 64'd0},
    '{ROW_WORD, 64'd0,                  1'b1, 1'b1, 64'd0},
    '{ROW_WORD, ALL1,                   1'b1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF},
    '{ROW_CFG,  64'd13,                 1'b0, 1'b0, 64'd0},
    '{ROW_WORD, 64'd1000,               1'b0, 1'b0, 64'd0},
    '{ROW_CFG,  64'd5,                  1'b0, 1'b0, 64'd0},  // modulus change mid-number
    '{ROW_WORD, 64'd77,                 1'b1, 1'b0, 64'd0},
    '{ROW_CFG,  64'h8000_0000_0000_0001, 1'b0, 1'b0, 64'd0},
    '{ROW_WORD, ALL1,                   1'b0, 1'b0, 64'd0},
    '{ROW_WORD, 64'hA5A5_5A5A_0F0F_F0F0, 1'b0, 1'b0, 64'd0},
    '{ROW_WORD, ALL1,                   1'b1, 1'b0, 64'd0},
    '{ROW_CFG,  64'd2,                  1'b0, 1'b0, 64'd0},
    '{ROW_WORD, 64'd1,                  1'b1, 1'b1, 64'd1},
    '{ROW_CFG,  64'd7,                  1'b0, 1'b0, 64'd0},
    '{ROW_WORD, 64'd0,                  1'b0, 1'b0, 64'd0},
    '{ROW_WORD, 64'd1,                  1'b1, 1'b0, 64'd0}
  };

  // DUT connections; every input known from time zero
  logic          clk        = 1'b0;
  logic          rst        = 1'b1;
  logic          modulus_we = 1'b0;
  logic [XW-1:0] modulus    = '0;
  logic          in_valid   = 1'b0;
  logic          in_ready;
  logic [XW-1:0] word_value = '0;
  logic          is_last    = 1'b0;
  logic          out_valid;
  logic          out_ready  = 1'b0;
  logic [XW-1:0] remainder;

  // Predictor state: what the block should hold after every accepted word
  logic [XW-1:0] cur_modulus;
  logic [XW-1:0] acc_rem;
  logic [XW-1:0] pos_weight;

  logic [XW-1:0] pending_remainders [$];
  int unsigned   n_errors  = 0;
  int unsigned   n_results = 0;
  int unsigned   n_sent    = 0;

  multiword_number_mod_reduce #(
    .WORD_BITS (WBITS)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .modulus_we (modulus_we),
    .modulus    (modulus),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .word_value (word_value),
    .is_last    (is_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .remainder  (remainder)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor. A zero modulus stands for 2^64, so arithmetic just wraps.
  // Products are formed at 128 bits and reduced exactly.
  // ---------------------------------------------------------------------------
  function automatic logic [XW-1:0] reduce_by(input logic [XW-1:0] a, input logic [XW-1:0] m);
    return (m == '0) ? a : a % m;
  endfunction

  function automatic logic [XW-1:0] add_mod(input logic [XW-1:0] a, input logic [XW-1:0] b,
                                            input logic [XW-1:0] m);
    logic [XW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (m != '0 && s >= {1'b0, m}) s = s - {1'b0, m};
    return s[XW-1:0];
  endfunction

  function automatic logic [XW-1:0] mul_mod(input logic [XW-1:0] a, input logic [XW-1:0] b,
                                            input logic [XW-1:0] m);
    logic [2*XW-1:0] p;
    if (m == '0) return a * b;
    p = {{XW{1'b0}}, a % m} * {{XW{1'b0}}, b % m};
    p = p % {{XW{1'b0}}, m};
    return p[XW-1:0];
  endfunction

  // 2^WORD_BITS mod m
  function automatic logic [XW-1:0] radix_mod(input logic [XW-1:0] m);
    logic [2*XW-1:0] r;
    if (m == '0) return (WBITS >= XW) ? '0 : (64'd1 << WBITS);
    r = (128'd1 << WBITS) % {{XW{1'b0}}, m};
    return r[XW-1:0];
  endfunction

  // Folds one accepted word into the running remainder; returns 1 when the
  // word closes a number, with the finished remainder in rem.
  function automatic bit fold_word(input logic [XW-1:0] w, input logic last,
                                   output logic [XW-1:0] rem);
    logic [XW:0]   mask_wide;
    logic [XW-1:0] term;
    mask_wide = (65'd1 << WBITS) - 65'd1;
    term       = mul_mod(w & mask_wide[XW-1:0], pos_weight, cur_modulus);
    acc_rem    = add_mod(reduce_by(acc_rem, cur_modulus), term, cur_modulus);
    pos_weight = mul_mod(pos_weight, radix_mod(cur_modulus), cur_modulus);
    rem = acc_rem;
    if (last) begin
      acc_rem    = '0;
      pos_weight = 64'd1;
    end
    return last;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Sender idles ~31% of the time, except for a quiet stretch of items.
  function automatic bit sender_gap();
    return !(n_sent >= 600 && n_sent < 800) && ($urandom_range(0, 99) < 31);
  endfunction

  // Offer one word; returns in the step of the edge that took the transaction.
  task automatic offer_word(input logic [XW-1:0] w, input logic last,
                            input logic known, input logic [XW-1:0] want);
    logic [XW-1:0] rem;
    while (sender_gap()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    word_value <= w;
    is_last    <= last;
    n_sent++;
    do @(posedge clk); while (!in_ready);
    if (fold_word(w, last, rem)) pending_remainders.push_back(known ? want : rem);
  endtask

  // Modulus is only written with the block quiet: nothing owed on the
  // output and any word still in flight given time to finish.
  task automatic write_modulus(input logic [XW-1:0] m);
    in_valid <= 1'b0;
    while (pending_remainders.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    modulus    <= m;
    modulus_we <= 1'b1;
    @(posedge clk);
    modulus_we  <= 1'b0;
    cur_modulus  = m;
  endtask

  function automatic logic [XW-1:0] pick_modulus(input int ph);
    case (ph % 8)
      0:       return '0;
      1:       return ALL1;
      2:       return 64'd1;
      3:       return 64'h8000_0000_0000_0000;
      4:       return 64'($urandom_range(2, 1000));
      5:       return {$urandom, $urandom};
      6:       return 64'd1 << $urandom_range(1, 63);
      default: return {32'hFFFF_FFFF, $urandom};
    endcase
  endfunction

  // Mostly full random words, with zeros, all-ones and small values mixed in
  function automatic logic [XW-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ALL1;
      2:       return 64'($urandom_range(0, 255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus: directed table, then random phases. Each phase writes a new
  // modulus; a phase can stop in the middle of a number, so the next write
  // lands mid-number as well.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned in_phase;
    int unsigned len;
    cur_modulus = 64'd1;
    acc_rem     = '0;
    pos_weight  = 64'd1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < N_ROWS; r++) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        write_modulus(dir_rows[r].value);
      end else begin
        offer_word(dir_rows[r].value, dir_rows[r].last, dir_rows[r].known, dir_rows[r].want);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_modulus(pick_modulus(ph));
      in_phase = 0;
      while (in_phase < ITEMS_PER_PHASE) begin
        // mostly short numbers, now and then a long one
        len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(5, 12);
        for (int k = 0; k < len && in_phase < ITEMS_PER_PHASE; k++) begin
          offer_word(pick_word(), (k == len - 1), 1'b0, '0);
          in_phase++;
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_remainders.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Output side: random stalls, one long hold-off so the block backs up and
  // stalls its input, and a stretch of results taken without any stall.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!held && n_results >= HOLD_AT_RESULT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (n_results >= 150 && n_results < 230) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 31);
      end
    end
  end

  // Result checker: every remainder transaction against the oldest expectation
  always @(posedge clk) begin
    logic [XW-1:0] want;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (pending_remainders.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("remainder %h with nothing expected", remainder);
      end else begin
        want = pending_remainders.pop_front();
        if (remainder !== want) begin
          n_errors++;
          if (n_errors <= 10) $display("remainder mismatch: expected %h, got %h", want, remainder);
        end
      end
    end
  end

endmodule
